// File: hw/rtl/assert_macros.svh
// assertion macros for the checker file
// no dependencies; expects clk and rst_n in the scope that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/sch1d_pkg.sv
// shared types, codes and arithmetic helpers of the 1d schrodinger step block
// no dependencies
`default_nettype none

package sch1d_pkg;

    localparam int MAX_POINTS_DEF = 1024;
    localparam int FRAC_BITS      = 28;

    localparam logic [28:0] ALPHA_RESET  = 29'd44739243;
    localparam logic [10:0] POINTS_RESET = 11'd1024;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_STEP  = 2'd2;

    localparam logic REG_ALPHA  = 1'b0;
    localparam logic REG_POINTS = 1'b1;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_ZERO_LO,
        ST_ZERO_HI,
        ST_SWEEP_RE,
        ST_SWEEP_IM,
        ST_DONE
    } state_t;

    // one point fed to the update pipeline
    typedef struct packed {
        logic valid;
        logic center;
        logic subtract;
    } feed_t;

    // round to nearest, ties away from zero, then saturate to signed 32 bits
    function automatic logic signed [32:0] round_sat(input logic [63:0] prod,
                                                     input logic neg);
        logic [63:0] r;
        r = (prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (neg) begin
            if (r > 64'd2147483648)
                r = 64'd2147483648;
            round_sat = 33'sd0 - $signed({1'b0, r[31:0]});
        end
        else begin
            if (r > 64'd2147483647)
                r = 64'd2147483647;
            round_sat = $signed({1'b0, r[31:0]});
        end
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/sch1d_pipe.sv
// point update pipeline: three-point window, two products, rounding, final sum
// depends on sch1d_pkg
`default_nettype none

module sch1d_pipe #(
    parameter int ADDR_W = 10
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire sch1d_pkg::feed_t    feed,
    input  wire        [ADDR_W-1:0]  feed_idx,
    input  wire        [28:0]        alpha,
    input  wire signed [31:0]        src_q,
    input  wire signed [31:0]        dst_q,
    input  wire        [30:0]        pot_q,
    output logic                     wr_valid,
    output logic       [ADDR_W-1:0]  wr_addr,
    output logic signed [31:0]       wr_data
);

    // window stage
    logic signed [31:0] s_cur_reg;
    logic signed [31:0] s_prev_reg;
    logic signed [31:0] dst_d_reg;
    logic        [31:0] coef_d_reg;
    logic [ADDR_W-1:0]  idx_d_reg;

    always_ff @(posedge clk)
    begin
        if (feed.valid)
        begin
            s_prev_reg <= s_cur_reg;
            s_cur_reg  <= src_q;
            dst_d_reg  <= dst_q;
            coef_d_reg <= {3'd0, alpha} + {1'b0, pot_q};
            idx_d_reg  <= feed_idx;
        end
    end

    // multiply stage
    logic signed [32:0] nsum;
    logic        [32:0] nmag;
    logic        [31:0] cmag;

    always_comb
    begin
        nsum = {src_q[31], src_q} + {s_prev_reg[31], s_prev_reg};
        nmag = nsum[32] ? 33'(-nsum) : 33'(nsum);
        cmag = s_cur_reg[31] ? 32'(-s_cur_reg) : 32'(s_cur_reg);
    end

    logic               m_valid_reg;
    logic        [63:0] m_p1_reg;
    logic        [63:0] m_p2_reg;
    logic               m_neg1_reg;
    logic               m_neg2_reg;
    logic signed [31:0] m_base_reg;
    logic [ADDR_W-1:0]  m_idx_reg;
    logic               m_sub_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else
            m_valid_reg <= feed.valid && feed.center;
    end

    always_ff @(posedge clk)
    begin
        m_p1_reg   <= {35'd0, alpha} * {31'd0, nmag};
        m_p2_reg   <= {32'd0, coef_d_reg} * {32'd0, cmag};
        m_neg1_reg <= nsum[32];
        m_neg2_reg <= s_cur_reg[31];
        m_base_reg <= dst_d_reg;
        m_idx_reg  <= idx_d_reg;
        m_sub_reg  <= feed.subtract;
    end

    // rounding stage
    logic               r_valid_reg;
    logic signed [32:0] r_q1_reg;
    logic signed [32:0] r_q2_reg;
    logic signed [31:0] r_base_reg;
    logic [ADDR_W-1:0]  r_idx_reg;
    logic               r_sub_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            r_valid_reg <= 1'b0;
        else
            r_valid_reg <= m_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        r_q1_reg   <= sch1d_pkg::round_sat(m_p1_reg, m_neg1_reg);
        r_q2_reg   <= sch1d_pkg::round_sat(m_p2_reg, m_neg2_reg);
        r_base_reg <= m_base_reg;
        r_idx_reg  <= m_idx_reg;
        r_sub_reg  <= m_sub_reg;
    end

    // final sum: base -/+ 2*(q1 - 2*q2), saturated
    logic signed [34:0] diff;
    logic signed [36:0] delta;
    logic signed [36:0] total;

    always_comb
    begin
        diff  = {{2{r_q1_reg[32]}}, r_q1_reg} - {r_q2_reg[32], r_q2_reg, 1'b0};
        delta = {diff[34], diff, 1'b0};
        if (r_sub_reg)
            total = {{5{r_base_reg[31]}}, r_base_reg} - delta;
        else
            total = {{5{r_base_reg[31]}}, r_base_reg} + delta;
        if (total > 37'sd2147483647)
            wr_data = 32'sh7fffffff;
        else if (total < -37'sd2147483648)
            wr_data = 32'sh80000000;
        else
            wr_data = total[31:0];
        wr_valid = r_valid_reg;
        wr_addr  = r_idx_reg;
    end

endmodule

`default_nettype wire

// File: hw/rtl/schrodinger_1d_leapfrog_step_top.sv
// Grid store and leapfrog time step of a 1d wavefunction in signed Q4.28. A write
// or an out-of-range read goes straight to the result state and an in-range read
// passes through a read state first; a step clears the two end points, then each
// half-update sweeps the grid at one point per cycle through the single read port
// of each memory, followed by a drain of the update pipeline. One word is worked
// on at a time; a finished result waits in the output register while the next
// word is accepted.
// depends on sch1d_pkg and sch1d_pipe
`default_nettype none

module schrodinger_1d_leapfrog_step_top #(
    parameter int MAX_POINTS = sch1d_pkg::MAX_POINTS_DEF
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               psel,
    input  wire               penable,
    input  wire               pwrite,
    input  wire        [2:0]  paddr,
    input  wire        [31:0] pwdata,
    output logic       [31:0] prdata,
    output logic              pready,
    input  wire               in_valid,
    output logic              in_ready,
    input  wire        [1:0]  op,
    input  wire        [9:0]  point_index,
    input  wire signed [31:0] re_value,
    input  wire signed [31:0] im_value,
    input  wire        [30:0] pot_term,
    output logic              out_valid,
    input  wire               out_ready,
    output logic              status,
    output logic signed [31:0] re_out,
    output logic signed [31:0] im_out
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 3);

    // configuration
    logic [28:0] alpha_reg;
    logic [10:0] pts_reg;
    logic [10:0] pts_clamped;
    logic        cfg_we;

    always_comb
    begin
        cfg_we = psel && penable && pwrite;
        if (pwdata[10:0] < 11'd3)
            pts_clamped = 11'd3;
        else if ({21'd0, pwdata[10:0]} > 32'(MAX_POINTS))
            pts_clamped = 11'(MAX_POINTS);
        else
            pts_clamped = pwdata[10:0];
        pready = 1'b1;
        if (paddr[2] == sch1d_pkg::REG_ALPHA)
            prdata = {3'd0, alpha_reg};
        else
            prdata = {21'd0, pts_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= sch1d_pkg::ALPHA_RESET;
            pts_reg   <= ({21'd0, sch1d_pkg::POINTS_RESET} > 32'(MAX_POINTS)) ?
                         11'(MAX_POINTS) : sch1d_pkg::POINTS_RESET;
        end
        else if (cfg_we)
        begin
            if (paddr[2] == sch1d_pkg::REG_ALPHA)
                alpha_reg <= pwdata[28:0];
            else
                pts_reg <= pts_clamped;
        end
    end

    // control
    sch1d_pkg::state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] sweep_end;
    logic          accept;
    logic          in_range;
    logic          out_free;
    logic          issue;

    logic              q_valid_reg;
    logic [AW-1:0]     q_idx_reg;

    logic [AW-1:0]     rd_addr;
    logic              re_we, im_we, pot_we;
    logic [AW-1:0]     re_wa, im_wa;
    logic signed [31:0] re_wd, im_wd;

    logic               pipe_wr_valid;
    logic [AW-1:0]      pipe_wr_addr;
    logic signed [31:0] pipe_wr_data;

    always_comb
    begin
        accept    = in_valid && in_ready;
        in_range  = {1'b0, point_index} < pts_reg;
        out_free  = !out_valid || out_ready;
        sweep_end = CW'(pts_reg) + CW'(2);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sch1d_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (op == sch1d_pkg::OP_STEP)
                        state_next = sch1d_pkg::ST_ZERO_LO;
                    else if (op == sch1d_pkg::OP_READ && in_range)
                        state_next = sch1d_pkg::ST_READ;
                    else
                        state_next = sch1d_pkg::ST_DONE;
                end
            end
            sch1d_pkg::ST_READ:     state_next = sch1d_pkg::ST_DONE;
            sch1d_pkg::ST_ZERO_LO:  state_next = sch1d_pkg::ST_ZERO_HI;
            sch1d_pkg::ST_ZERO_HI:  state_next = sch1d_pkg::ST_SWEEP_RE;
            sch1d_pkg::ST_SWEEP_RE:
            begin
                if (cnt_reg == sweep_end)
                    state_next = sch1d_pkg::ST_SWEEP_IM;
            end
            sch1d_pkg::ST_SWEEP_IM:
            begin
                if (cnt_reg == sweep_end)
                    state_next = sch1d_pkg::ST_DONE;
            end
            sch1d_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = sch1d_pkg::ST_IDLE;
            end
            default: state_next = sch1d_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        rd_addr  = cnt_reg[AW-1:0];
        issue    = 1'b0;
        cnt_next = '0;
        re_we    = 1'b0;
        im_we    = 1'b0;
        pot_we   = 1'b0;
        re_wa    = AW'(point_index);
        im_wa    = AW'(point_index);
        re_wd    = re_value;
        im_wd    = im_value;
        case (state_reg)
            sch1d_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                rd_addr  = AW'(point_index);
                if (accept && op == sch1d_pkg::OP_WRITE && in_range)
                begin
                    re_we  = 1'b1;
                    im_we  = 1'b1;
                    pot_we = 1'b1;
                end
            end
            sch1d_pkg::ST_ZERO_LO:
            begin
                re_we = 1'b1;
                im_we = 1'b1;
                re_wa = '0;
                im_wa = '0;
                re_wd = '0;
                im_wd = '0;
            end
            sch1d_pkg::ST_ZERO_HI:
            begin
                re_we = 1'b1;
                im_we = 1'b1;
                re_wa = AW'(pts_reg - 11'd1);
                im_wa = AW'(pts_reg - 11'd1);
                re_wd = '0;
                im_wd = '0;
            end
            sch1d_pkg::ST_SWEEP_RE:
            begin
                issue    = cnt_reg < CW'(pts_reg);
                cnt_next = (cnt_reg == sweep_end) ? '0 : cnt_reg + CW'(1);
                re_we    = pipe_wr_valid;
                re_wa    = pipe_wr_addr;
                re_wd    = pipe_wr_data;
            end
            sch1d_pkg::ST_SWEEP_IM:
            begin
                issue    = cnt_reg < CW'(pts_reg);
                cnt_next = (cnt_reg == sweep_end) ? '0 : cnt_reg + CW'(1);
                im_we    = pipe_wr_valid;
                im_wa    = pipe_wr_addr;
                im_wd    = pipe_wr_data;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sch1d_pkg::ST_IDLE;
            cnt_reg     <= '0;
            q_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            q_valid_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        q_idx_reg <= cnt_reg[AW-1:0];
    end

    // grid memories, registered read
    logic signed [31:0] re_mem [MAX_POINTS];
    logic signed [31:0] im_mem [MAX_POINTS];
    logic        [30:0] pot_mem [MAX_POINTS];
    logic signed [31:0] re_q;
    logic signed [31:0] im_q;
    logic        [30:0] pot_q;

    always_ff @(posedge clk)
    begin
        if (re_we)
            re_mem[re_wa] <= re_wd;
        re_q <= re_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (im_we)
            im_mem[im_wa] <= im_wd;
        im_q <= im_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (pot_we)
            pot_mem[AW'(point_index)] <= pot_term;
        pot_q <= pot_mem[rd_addr];
    end

    // update pipeline: real sweep reads imag, imag sweep reads new real
    sch1d_pkg::feed_t feed;
    logic             sweep_re;

    always_comb
    begin
        sweep_re      = state_reg == sch1d_pkg::ST_SWEEP_RE;
        feed.valid    = q_valid_reg;
        feed.center   = q_idx_reg >= AW'(2);
        feed.subtract = sweep_re;
    end

    sch1d_pipe #(
        .ADDR_W (AW)
    ) u_pipe (
        .clk      (clk),
        .rst_n    (rst_n),
        .feed     (feed),
        .feed_idx (q_idx_reg),
        .alpha    (alpha_reg),
        .src_q    (sweep_re ? im_q : re_q),
        .dst_q    (sweep_re ? re_q : im_q),
        .pot_q    (pot_q),
        .wr_valid (pipe_wr_valid),
        .wr_addr  (pipe_wr_addr),
        .wr_data  (pipe_wr_data)
    );

    // result word and output register
    logic               res_status;
    logic signed [31:0] res_re;
    logic signed [31:0] res_im;
    logic               out_valid_reg;
    logic               out_status_reg;
    logic signed [31:0] out_re_reg;
    logic signed [31:0] out_im_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_status <= ((op == sch1d_pkg::OP_WRITE || op == sch1d_pkg::OP_READ) &&
                           !in_range) ? sch1d_pkg::STATUS_RANGE : sch1d_pkg::STATUS_OK;
            res_re <= '0;
            res_im <= '0;
        end
        else if (state_reg == sch1d_pkg::ST_READ)
        begin
            res_re <= re_q;
            res_im <= im_q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == sch1d_pkg::ST_DONE && out_free)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == sch1d_pkg::ST_DONE && out_free)
        begin
            out_status_reg <= res_status;
            out_re_reg     <= res_re;
            out_im_reg     <= res_im;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign re_out    = out_re_reg;
    assign im_out    = out_im_reg;

endmodule

`default_nettype wire

// File: hw/rtl/sch1d_checker.sv
// port-level checks for the 1d schrodinger step block, bound to the top level
// depends on assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module sch1d_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        in_valid,
    input wire        in_ready,
    input wire        out_valid,
    input wire        out_ready,
    input wire        status,
    input wire [31:0] re_out,
    input wire [31:0] im_out
);

    // one word in flight: input closes right after an accept
    `CHK_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")

    // a new result only appears while a word is being worked on
    `CHK_SAME(a_result_from_work, $rose(out_valid), $past(!in_ready), "result without work")

    // range error carries zero values
    `CHK_SAME(a_range_zero, out_valid && status, re_out == 32'd0 && im_out == 32'd0,
              "range error with data")

    // stalled result holds
    `CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(re_out) &&
              $stable(im_out) && $stable(status), "stalled result changed")

endmodule

bind schrodinger_1d_leapfrog_step_top sch1d_checker u_sch1d_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .re_out    (re_out),
    .im_out    (im_out)
);

`default_nettype wire
